### rtl/core/hc3d_pkg.sv
`timescale 1ns / 1ps

package hc3d_pkg;

    localparam int LETTER_W    = 5;
    localparam int KEY_ROW_W   = 15;
    localparam int CFG_INDEX_W = 2;
    localparam int PROD_W      = 2 * LETTER_W;
    localparam int SUM_W       = 12;
    localparam int RECIP_SHIFT = 16;
    localparam int QUOT_W      = 8;

    localparam logic [LETTER_W-1:0] MODULUS  = 5'd26;
    localparam logic [SUM_W-1:0]    MOD_SQ   = 12'd676;
    localparam logic [SUM_W-1:0]    RECIP_26 = 12'd2521;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ROW_ZERO = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ROW_ONE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ROW_TWO  = 2'd2;

    typedef logic [LETTER_W-1:0] letter_t;

    typedef struct packed {
        letter_t cipher_letter;
        logic    end_of_text;
    } cipher_t;

    typedef struct packed {
        letter_t plain_letter;
        logic    last_of_block;
        logic    key_not_invertible;
    } plain_t;

    typedef logic [2:0][LETTER_W-1:0] block_t;
    typedef logic [8:0][LETTER_W-1:0] key_mat_t;

    typedef struct packed {
        logic   push;
        block_t blk;
    } blk_push_t;

    typedef struct packed {
        logic   avail;
        block_t blk;
    } blk_head_t;

    typedef struct packed {
        logic busy;
        logic valid;
    } key_stat_t;

    // Remainder by 26 through a reciprocal multiply; exact for any 12-bit value
    function automatic letter_t mod26(input logic [SUM_W-1:0] v);
        logic [2*SUM_W-1:0] prod;
        logic [QUOT_W-1:0]  quot;
        logic [SUM_W-1:0]   rem;
        prod = {{SUM_W{1'b0}}, v} * {{SUM_W{1'b0}}, RECIP_26};
        quot = prod[RECIP_SHIFT +: QUOT_W];
        rem  = v - SUM_W'({{(SUM_W-QUOT_W){1'b0}}, quot} * SUM_W'(MODULUS));
        return rem[LETTER_W-1:0];
    endfunction

    function automatic letter_t reduce_entry(input letter_t e);
        return (e >= MODULUS) ? letter_t'(e - MODULUS) : e;
    endfunction

endpackage

### rtl/core/hc3d_stream_if.sv
`timescale 1ns / 1ps

interface hc3d_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/hc3d_front.sv
`timescale 1ns / 1ps

module hc3d_front (
    input  logic                clk,
    input  logic                rst_n,
    hc3d_stream_if.sink         cipher,
    input  logic                q_full,
    output hc3d_pkg::blk_push_t push
);
    import hc3d_pkg::*;

    logic [1:0]    pos_reg, pos_next;
    letter_t [1:0] held_reg, held_next;
    logic          accept;
    logic          completes;

    assign completes    = (pos_reg == 2'd2);
    assign cipher.ready = !completes || !q_full;
    assign accept       = cipher.valid && cipher.ready;

    assign push.push   = accept && completes;
    assign push.blk[0] = held_reg[0];
    assign push.blk[1] = held_reg[1];
    assign push.blk[2] = cipher.payload.cipher_letter;

    always_comb
    begin
        pos_next  = pos_reg;
        held_next = held_reg;
        if (accept)
        begin
            if (completes || cipher.payload.end_of_text)
            begin
                // drop a partial block at end of text
                pos_next = 2'd0;
            end
            else
            begin
                pos_next = pos_reg + 2'd1;
            end
            if (!completes)
            begin
                held_next[pos_reg[0]] = cipher.payload.cipher_letter;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 2'd0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

### rtl/core/hc3d_queue.sv
`timescale 1ns / 1ps

module hc3d_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  hc3d_pkg::blk_push_t push,
    input  logic                pop,
    output logic                full,
    output hc3d_pkg::blk_head_t head
);
    import hc3d_pkg::*;

    localparam logic [1:0] QDEPTH = 2'd2;

    block_t [1:0] entry_reg;
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full       = (count_reg == QDEPTH);
    assign head.avail = (count_reg != 2'd0);
    assign head.blk   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push.push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push.push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            entry_reg[wr_ptr_reg] <= push.blk;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QDEPTH) |-> !push.push)
        else $error("block queue written while full");

endmodule

### rtl/core/hc3d_key_unit.sv
`timescale 1ns / 1ps

module hc3d_key_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [hc3d_pkg::CFG_INDEX_W-1:0]      wr_index,
    input  logic [hc3d_pkg::KEY_ROW_W-1:0]        wr_data,
    output hc3d_pkg::key_stat_t                   stat,
    output hc3d_pkg::key_mat_t                    inv_key
);
    import hc3d_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADJ_MUL,
        S_ADJ_RED,
        S_DET_MUL,
        S_DET_ACC,
        S_SEARCH,
        S_SCL_MUL,
        S_SCL_RED
    } state_t;

    typedef struct packed {
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] c;
        logic [3:0] d;
    } adj_ops_t;

    // Adjugate entry n is k[a]*k[b] - k[c]*k[d], row-major flat indices
    function automatic adj_ops_t adj_ops(input logic [3:0] n);
        adj_ops_t ops;
        case (n)
            4'd0:    ops = '{4'd4, 4'd8, 4'd5, 4'd7};
            4'd1:    ops = '{4'd2, 4'd7, 4'd1, 4'd8};
            4'd2:    ops = '{4'd1, 4'd5, 4'd2, 4'd4};
            4'd3:    ops = '{4'd5, 4'd6, 4'd3, 4'd8};
            4'd4:    ops = '{4'd0, 4'd8, 4'd2, 4'd6};
            4'd5:    ops = '{4'd2, 4'd3, 4'd0, 4'd5};
            4'd6:    ops = '{4'd3, 4'd7, 4'd4, 4'd6};
            4'd7:    ops = '{4'd1, 4'd6, 4'd0, 4'd7};
            4'd8:    ops = '{4'd0, 4'd4, 4'd1, 4'd3};
            default: ops = '{4'd0, 4'd0, 4'd0, 4'd0};
        endcase
        return ops;
    endfunction

    localparam logic [3:0]    LAST_ENTRY = 4'd8;
    localparam logic [3:0]    LAST_COL   = 4'd2;
    localparam letter_t       LAST_X     = 5'd25;

    state_t              state_reg, state_next;
    logic                valid_reg, valid_next;
    key_mat_t            k_reg, k_next;
    key_mat_t            adj_reg, adj_next;
    key_mat_t            inv_reg, inv_next;
    logic [3:0]          step_reg, step_next;
    logic [PROD_W-1:0]   p1_reg, p1_next;
    logic [PROD_W-1:0]   p2_reg, p2_next;
    letter_t             det_reg, det_next;
    letter_t             res_reg, res_next;
    letter_t             x_reg, x_next;
    letter_t             dinv_reg, dinv_next;

    logic                wr_hit;
    adj_ops_t            ops;
    logic [3:0]          row_base;
    logic [3:0]          det_adj_idx;
    logic [SUM_W-1:0]    det_sum;
    letter_t             det_mod;
    logic [LETTER_W:0]   res_sum;

    assign wr_hit      = wr_en && (wr_index <= REG_KEY_ROW_TWO);
    assign ops         = adj_ops(step_reg);
    assign row_base    = 4'({2'b00, wr_index} * 4'd3);
    assign det_adj_idx = 4'(step_reg * 4'd3);
    assign det_sum     = SUM_W'(det_reg) + SUM_W'(p1_reg);
    assign det_mod     = mod26(det_sum);
    assign res_sum     = {1'b0, res_reg} + {1'b0, det_reg};

    assign stat.busy  = (state_reg != S_IDLE) || wr_hit;
    assign stat.valid = valid_reg;
    assign inv_key    = inv_reg;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        k_next     = k_reg;
        adj_next   = adj_reg;
        inv_next   = inv_reg;
        step_next  = step_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        det_next   = det_reg;
        res_next   = res_reg;
        x_next     = x_reg;
        dinv_next  = dinv_reg;

        case (state_reg)
            S_IDLE:
            begin
            end
            S_ADJ_MUL:
            begin
                p1_next    = PROD_W'(k_reg[ops.a]) * PROD_W'(k_reg[ops.b]);
                p2_next    = PROD_W'(k_reg[ops.c]) * PROD_W'(k_reg[ops.d]);
                state_next = S_ADJ_RED;
            end
            S_ADJ_RED:
            begin
                // bias by 26*26 to keep the difference positive
                adj_next[step_reg] = mod26(SUM_W'(p1_reg) + MOD_SQ - SUM_W'(p2_reg));
                if (step_reg == LAST_ENTRY)
                begin
                    step_next  = 4'd0;
                    det_next   = '0;
                    state_next = S_DET_MUL;
                end
                else
                begin
                    step_next  = step_reg + 4'd1;
                    state_next = S_ADJ_MUL;
                end
            end
            S_DET_MUL:
            begin
                p1_next    = PROD_W'(k_reg[step_reg]) * PROD_W'(adj_reg[det_adj_idx]);
                state_next = S_DET_ACC;
            end
            S_DET_ACC:
            begin
                det_next = det_mod;
                if (step_reg == LAST_COL)
                begin
                    res_next   = det_mod;
                    x_next     = 5'd1;
                    state_next = S_SEARCH;
                end
                else
                begin
                    step_next  = step_reg + 4'd1;
                    state_next = S_DET_MUL;
                end
            end
            S_SEARCH:
            begin
                // res holds det * x mod 26
                if (res_reg == 5'd1)
                begin
                    dinv_next  = x_reg;
                    step_next  = 4'd0;
                    state_next = S_SCL_MUL;
                end
                else if (x_reg == LAST_X)
                begin
                    valid_next = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    x_next   = x_reg + 5'd1;
                    res_next = (res_sum >= {1'b0, MODULUS}) ?
                               letter_t'(res_sum - {1'b0, MODULUS}) : letter_t'(res_sum);
                end
            end
            S_SCL_MUL:
            begin
                p1_next    = PROD_W'(adj_reg[step_reg]) * PROD_W'(dinv_reg);
                state_next = S_SCL_RED;
            end
            S_SCL_RED:
            begin
                inv_next[step_reg] = mod26(SUM_W'(p1_reg));
                if (step_reg == LAST_ENTRY)
                begin
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    step_next  = step_reg + 4'd1;
                    state_next = S_SCL_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a key write restarts the derivation from the top
        if (wr_hit)
        begin
            for (int c = 0; c < 3; c++)
            begin
                k_next[row_base + 4'(c)] = reduce_entry(wr_data[c*LETTER_W +: LETTER_W]);
            end
            valid_next = 1'b0;
            step_next  = 4'd0;
            state_next = S_ADJ_MUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            k_reg     <= '0;
            step_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            k_reg     <= k_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adj_reg  <= adj_next;
        inv_reg  <= inv_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        det_reg  <= det_next;
        res_reg  <= res_next;
        x_reg    <= x_next;
        dinv_reg <= dinv_next;
    end

    a_write_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        wr_hit |=> stat.busy && !stat.valid)
        else $error("key write did not restart the inverse derivation");

    a_valid_from_scale: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> ($past(state_reg) == S_SCL_RED))
        else $error("inverse key marked valid outside the scaling pass");

endmodule

### rtl/core/hc3d_back.sv
`timescale 1ns / 1ps

module hc3d_back (
    input  logic                clk,
    input  logic                rst_n,
    input  hc3d_pkg::blk_head_t head,
    output logic                pop,
    input  hc3d_pkg::key_stat_t kstat,
    input  hc3d_pkg::key_mat_t  inv_key,
    hc3d_stream_if.source       plain
);
    import hc3d_pkg::*;

    typedef enum logic {
        B_IDLE,
        B_MAC
    } state_t;

    localparam logic [1:0] LAST_IDX = 2'd2;

    state_t            state_reg, state_next;
    logic [1:0]        row_reg, row_next;
    logic [1:0]        col_reg, col_next;
    logic              sum_valid_reg, sum_valid_next;
    logic              sum_last_reg, sum_last_next;
    logic              sum_flag_reg, sum_flag_next;
    logic              out_valid_reg, out_valid_next;
    plain_t            out_reg, out_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    block_t            v_reg, v_next;

    logic              out_free;
    logic              sum_move;
    logic              sum_free;
    logic [3:0]        mac_idx;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  acc_sum;

    assign out_free = !out_valid_reg || plain.ready;
    assign sum_move = sum_valid_reg && out_free;
    assign sum_free = !sum_valid_reg || sum_move;
    assign mac_idx  = 4'({2'b00, row_reg} * 4'd3) + {2'b00, col_reg};
    assign prod     = PROD_W'(inv_key[mac_idx]) * PROD_W'(v_reg[col_reg]);
    assign acc_sum  = acc_reg + SUM_W'(prod);

    assign pop = (state_reg == B_IDLE) && head.avail && !kstat.busy &&
                 (kstat.valid || sum_free);

    assign plain.valid   = out_valid_reg;
    assign plain.payload = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        acc_next       = acc_reg;
        v_next         = v_reg;
        sum_valid_next = sum_valid_reg && !sum_move;
        sum_next       = sum_reg;
        sum_last_next  = sum_last_reg;
        sum_flag_next  = sum_flag_reg;
        out_valid_next = out_valid_reg && !plain.ready;
        out_next       = out_reg;

        if (sum_move)
        begin
            out_valid_next             = 1'b1;
            out_next.plain_letter       = mod26(sum_reg);
            out_next.last_of_block      = sum_last_reg;
            out_next.key_not_invertible = sum_flag_reg;
        end

        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    if (kstat.valid)
                    begin
                        v_next     = head.blk;
                        row_next   = 2'd0;
                        col_next   = 2'd0;
                        acc_next   = '0;
                        state_next = B_MAC;
                    end
                    else
                    begin
                        // one flagged result stands for the whole block
                        sum_valid_next = 1'b1;
                        sum_next       = '0;
                        sum_last_next  = 1'b1;
                        sum_flag_next  = 1'b1;
                    end
                end
            end
            B_MAC:
            begin
                if (col_reg != LAST_IDX)
                begin
                    acc_next = acc_sum;
                    col_next = col_reg + 2'd1;
                end
                else if (sum_free)
                begin
                    sum_valid_next = 1'b1;
                    sum_next       = acc_sum;
                    sum_last_next  = (row_reg == LAST_IDX);
                    sum_flag_next  = 1'b0;
                    acc_next       = '0;
                    col_next       = 2'd0;
                    if (row_reg == LAST_IDX)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            row_reg       <= 2'd0;
            col_reg       <= 2'd0;
            sum_valid_reg <= 1'b0;
            sum_last_reg  <= 1'b0;
            sum_flag_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            sum_valid_reg <= sum_valid_next;
            sum_last_reg  <= sum_last_next;
            sum_flag_reg  <= sum_flag_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        v_reg   <= v_next;
        sum_reg <= sum_next;
    end

    a_pop_key_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (head.avail && !kstat.busy))
        else $error("block taken while the inverse key is not settled");

    a_flagged_block: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !kstat.valid) |=> (sum_valid_reg && sum_flag_reg && sum_last_reg))
        else $error("block under a singular key did not give a flagged result");

endmodule

### rtl/core/hill_cipher_3x3_decrypt.sv
`timescale 1ns / 1ps
// The back end runs the nine multiply-accumulates of a three-letter block one after another on its
// single shared 5x5 multiplier, after one load step, and takes no new block until the last row's sum
// is handed on; a flagged block gives one result.
// A key write starts an inverse derivation; blocks wait in the queue meanwhile.
// Reset (rst_n low, asynchronous): key rows zero, inverse invalid, queue and partial block empty.
module hill_cipher_3x3_decrypt (
    input  logic                             clk,
    input  logic                             rst_n,
    hc3d_stream_if.sink                      cipher,
    hc3d_stream_if.source                    plain,
    input  logic                             wr_en,
    input  logic [hc3d_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [hc3d_pkg::KEY_ROW_W-1:0]   wr_data
);
    import hc3d_pkg::*;

    blk_push_t push;
    blk_head_t head;
    logic      q_full;
    logic      pop;
    key_stat_t kstat;
    key_mat_t  inv_key;

    hc3d_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cipher (cipher),
        .q_full (q_full),
        .push   (push)
    );

    hc3d_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    hc3d_key_unit u_key_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .stat     (kstat),
        .inv_key  (inv_key)
    );

    hc3d_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .kstat   (kstat),
        .inv_key (inv_key),
        .plain   (plain)
    );

endmodule
